// File: rtl/isfp_pkg.sv
package isfp_pkg;

	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam int STORE_DEPTH = 9;
	localparam int POS_W = $clog2(STORE_DEPTH);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_TYPE    = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CHECK   = 2'd3
	} isfp_phase_t;

	// One decoded frame; packed lowest field last so it maps straight onto tdata.
	typedef struct packed {
		logic signed [15:0] value_d;
		logic signed [15:0] value_c;
		logic signed [15:0] value_b;
		logic signed [15:0] value_a;
		logic        [7:0]  frame_type;
	} isfp_result_t;

	typedef struct packed {
		logic             hit;
		isfp_phase_t      phase;
		logic [POS_W-1:0] pos;
	} isfp_stat_t;

endpackage

// File: rtl/imu_serial_frame_parser.sv
// Frames 11-byte sensor packets out of a UART byte stream: header 0x55, type
// byte, eight payload bytes, and a checksum equal to the 8-bit sum of the
// first ten bytes. Each accepted input item is one received byte. A frame
// with a good checksum yields one output item holding the type byte and four
// little-endian signed 16-bit words; a bad frame is dropped without notice.
// A checksum byte of 0x55 also opens the next frame. Bytes are taken one per
// cycle while the output is not stalled: each item is registered on entry,
// moves through the framer (one 8-bit add and compare) once the output
// register can take a result, and a result lands in the output register,
// raising m_axis_tvalid, at that edge. s_axis_tready drops only while the
// output register holds an item that the sink is not taking.
module imu_serial_frame_parser
	import isfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // [7:0] frame_type, [23:8] value_a,
	                                   // [39:24] value_b, [55:40] value_c,
	                                   // [71:56] value_d
);

	// input register
	logic         in_valid_s1;
	logic [7:0]   in_byte_s1;
	// output register
	logic         out_valid_q;
	isfp_result_t out_q;

	logic         advance;
	isfp_stat_t   stat;
	isfp_result_t result;

	// the byte in stage 1 moves on once the output register can take a result
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			in_byte_s1 <= s_axis_tdata;
	end

	isfp_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (in_byte_s1),
		.stat    (stat),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && stat.hit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stat.hit)
			out_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// a good checksum always lands a result
	a_hit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && stat.hit |=> m_axis_tvalid)
		else $error("checked frame did not reach the output register");

	// payload collection only ever sees store positions 1..8
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.phase == PH_PAYLOAD |->
			stat.pos >= POS_W'(1) && stat.pos < POS_W'(STORE_DEPTH))
		else $error("payload position out of range");

	// idle between frames leaves the position cleared
	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		stat.phase == PH_HEADER |-> stat.pos == '0)
		else $error("position not cleared while hunting for header");

	// an empty input register never blocks the source
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty input register");

endmodule

// File: rtl/isfp_framer.sv
module isfp_framer
	import isfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte,
	output isfp_stat_t   stat,
	output isfp_result_t result
);

	isfp_phase_t      phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       store_q [STORE_DEPTH];
	logic             wr_en;
	logic [POS_W-1:0] wr_addr;
	logic             pos_ok;

	assign pos_ok = (pos_q >= POS_W'(1)) && (pos_q < POS_W'(STORE_DEPTH));

	// next state
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		sum_d   = sum_q;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		case (phase_q)
			PH_HEADER: begin
				if (rx_byte == HDR_BYTE) begin
					phase_d = PH_TYPE;
					pos_d   = '0;
					sum_d   = HDR_BYTE;
				end
			end
			PH_TYPE: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				sum_d   = sum_q + rx_byte;
				pos_d   = POS_W'(1);
				phase_d = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (pos_ok) begin
					wr_en = 1'b1;
					sum_d = sum_q + rx_byte;
					pos_d = pos_q + POS_W'(1);
					if (pos_q == POS_W'(STORE_DEPTH - 1))
						phase_d = PH_CHECK;
				end else begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				// a checksum byte equal to the header opens the next frame
				if (rx_byte == HDR_BYTE) begin
					phase_d = PH_TYPE;
					pos_d   = '0;
					sum_d   = HDR_BYTE;
				end else begin
					phase_d = PH_HEADER;
					pos_d   = '0;
					sum_d   = '0;
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	// outputs
	always_comb begin
		stat.hit   = (phase_q == PH_CHECK) && (sum_q == rx_byte);
		stat.phase = phase_q;
		stat.pos   = pos_q;
		result.frame_type = store_q[0];
		result.value_a    = {store_q[2], store_q[1]};
		result.value_b    = {store_q[4], store_q[3]};
		result.value_c    = {store_q[6], store_q[5]};
		result.value_d    = {store_q[8], store_q[7]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en)
			store_q[wr_addr] <= rx_byte;
	end

endmodule
